// ----- rtl/nbds_pkg.sv -----
`timescale 1ns / 1ps
// Package for the all-pairs gravity step: widths, codes, register defaults
// and fixed-point constants. Depends on nothing.
package nbds_pkg;

   // Operand and product widths of the shared multiplier.
   localparam int MUL_W  = 34;
   localparam int PROD_W = 2 * MUL_W;

   // Squared distance, exponent and accumulator widths.
   localparam int D2_W   = 50;
   localparam int TE_W   = 7;
   localparam int ACC_W  = 57;
   localparam int MASS_W = 31;

   // Configuration channel.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 31;

   localparam logic [CSR_IDX_W-1:0] CSR_BODY_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SOFTENING  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_STEP  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DAMPING    = 2'd3;

   localparam logic [6:0]  BODY_COUNT_RESET = 7'd64;
   localparam logic [30:0] SOFTENING_RESET  = 31'd65536;
   localparam logic [16:0] TIME_STEP_RESET  = 17'd655;
   localparam logic [16:0] DAMPING_RESET    = 17'd65536;

   // Request function codes.
   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_STEP = 1'b1;

   // Q2.30 constants for the inverse square root.
   localparam logic [31:0] Q30_TWO    = 32'h8000_0000;
   localparam logic [31:0] Q30_THREE  = 32'hC000_0000;
   localparam logic [31:0] Q30_SQRT2  = 32'd1518500250;
   localparam logic [31:0] SLOPE_LOW  = 32'd2515933591;
   localparam logic [31:0] SLOPE_HIGH = 32'd889516847;

endpackage

// ----- rtl/nbds_if.sv -----
`timescale 1ns / 1ps
// Channel interfaces of the gravity step: request, response and register
// write channels. Depends on nbds_pkg.
interface nbds_req_if;
   import nbds_pkg::*;
   logic                valid;
   logic                ready;
   logic                func;
   logic [5:0]          index;
   logic signed [31:0]  pos_x;
   logic signed [31:0]  pos_y;
   logic signed [31:0]  vel_x;
   logic signed [31:0]  vel_y;
   logic [MASS_W-1:0]   mass;
   modport source (output valid, func, index, pos_x, pos_y, vel_x, vel_y, mass,
                   input ready);
   modport sink   (input valid, func, index, pos_x, pos_y, vel_x, vel_y, mass,
                   output ready);
endinterface

interface nbds_rsp_if;
   logic                valid;
   logic                ready;
   logic [5:0]          out_index;
   logic signed [31:0]  new_pos_x;
   logic signed [31:0]  new_pos_y;
   logic signed [31:0]  new_vel_x;
   logic signed [31:0]  new_vel_y;
   logic                last;
   modport source (output valid, out_index, new_pos_x, new_pos_y, new_vel_x,
                   new_vel_y, last, input ready);
   modport sink   (input valid, out_index, new_pos_x, new_pos_y, new_vel_x,
                   new_vel_y, last, output ready);
endinterface

interface nbds_csr_if;
   import nbds_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/nbds_mul.sv -----
`timescale 1ns / 1ps
// Shared unsigned multiplier with a registered product.
// Depends on nbds_pkg for the operand widths.
module nbds_mul (
   input  logic                        clock,
   input  logic [nbds_pkg::MUL_W-1:0]  op_a,
   input  logic [nbds_pkg::MUL_W-1:0]  op_b,
   output logic [nbds_pkg::PROD_W-1:0] prod_ff
);
   import nbds_pkg::*;

   logic [PROD_W-1:0] prod_in;

   // One product per cycle, available the cycle after the operands.
   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ----- rtl/nbds_norm.sv -----
`timescale 1ns / 1ps
// Iterative normaliser: scales the squared distance by even powers of two
// into [2^30, 2^32) and tracks the exponent. Depends on nbds_pkg.
module nbds_norm (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [nbds_pkg::D2_W-1:0]        d2,
   output logic                             done,
   output logic [31:0]                      f,
   output logic signed [nbds_pkg::TE_W-1:0] two_e
);
   import nbds_pkg::*;

   logic [D2_W-1:0]        w_ff, w_in;
   logic signed [TE_W-1:0] te_ff, te_in;
   logic                   busy_ff, busy_in;
   logic                   in_range;

   // The word is normalised once its top set bit is bit 30 or 31.
   assign in_range = (w_ff[D2_W-1:32] == '0) && (w_ff[31:30] != 2'b00);
   assign done     = busy_ff && in_range;
   assign f        = w_ff[31:0];
   assign two_e    = te_ff;

   // Coarse steps of eight bits first, then steps of two.
   always_comb begin
      w_in    = w_ff;
      te_in   = te_ff;
      busy_in = busy_ff;
      if (start) begin
         w_in    = d2;
         te_in   = TE_W'(16);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (in_range) begin
            busy_in = 1'b0;
         end else if (w_ff[D2_W-1:40] != '0) begin
            w_in  = w_ff >> 8;
            te_in = te_ff + TE_W'(8);
         end else if (w_ff[39:32] != '0) begin
            w_in  = w_ff >> 2;
            te_in = te_ff + TE_W'(2);
         end else if (w_ff[29:22] == '0) begin
            w_in  = w_ff << 8;
            te_in = te_ff - TE_W'(8);
         end else begin
            w_in  = w_ff << 2;
            te_in = te_ff - TE_W'(2);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      w_ff  <= w_in;
      te_ff <= te_in;
   end

endmodule

// ----- rtl/nbody_direct_sum_step.sv -----
`timescale 1ns / 1ps
// Top level of the softened all-pairs gravity step: sequencer, body stores
// and configuration registers. Depends on nbds_pkg, nbds_if, nbds_mul, nbds_norm.
//
// A load beat writes one body into its slot. A step beat runs every ordered
// pair of bodies through one shared 34 by 34 multiplier under a sequencer,
// with the iterative normaliser and an inverse square root of
// RSQRT_ITERATIONS iterations for each pair; a pair whose softened squared
// distance is zero skips them and adds nothing. Each body is then
// integrated, and once all bodies are done the results go out as response
// beats, which the response channel can hold back with back-pressure.
// The request channel is ready only while no step is running; register
// writes are taken at any time.
module nbody_direct_sum_step #(
   parameter int MAX_BODIES       = 64,
   parameter int RSQRT_ITERATIONS = 3
) (
   input  logic   clock,
   input  logic   reset,
   nbds_req_if.sink   req_if,
   nbds_rsp_if.source rsp_if,
   nbds_csr_if.sink   csr_if
);
   import nbds_pkg::*;

   localparam int AW = $clog2(MAX_BODIES);
   localparam int CW = $clog2(MAX_BODIES + 1);
   localparam int IW = $clog2(RSQRT_ITERATIONS + 1);

   // Sequencer states.
   localparam logic [4:0] S_IDLE      = 5'd0;
   localparam logic [4:0] S_BODY_RD   = 5'd1;
   localparam logic [4:0] S_BODY_CAP  = 5'd2;
   localparam logic [4:0] S_PAIR_RD   = 5'd3;
   localparam logic [4:0] S_PAIR_DIFF = 5'd4;
   localparam logic [4:0] S_SQ_X      = 5'd5;
   localparam logic [4:0] S_SQ_Y      = 5'd6;
   localparam logic [4:0] S_D2        = 5'd7;
   localparam logic [4:0] S_NORM      = 5'd8;
   localparam logic [4:0] S_SEED      = 5'd9;
   localparam logic [4:0] S_SEED_Y    = 5'd10;
   localparam logic [4:0] S_NT_A      = 5'd11;
   localparam logic [4:0] S_NT_B      = 5'd12;
   localparam logic [4:0] S_NT_C      = 5'd13;
   localparam logic [4:0] S_NT_D      = 5'd14;
   localparam logic [4:0] S_NT_E      = 5'd15;
   localparam logic [4:0] S_FIN_A     = 5'd16;
   localparam logic [4:0] S_FIN_B     = 5'd17;
   localparam logic [4:0] S_FIN_M     = 5'd18;
   localparam logic [4:0] S_FIN_U     = 5'd19;
   localparam logic [4:0] S_FIN_UY    = 5'd20;
   localparam logic [4:0] S_FIN_T     = 5'd21;
   localparam logic [4:0] S_FIN_C     = 5'd22;
   localparam logic [4:0] S_FIN_ACC   = 5'd23;
   localparam logic [4:0] S_INT_MAG   = 5'd24;
   localparam logic [4:0] S_INT_MUL   = 5'd25;
   localparam logic [4:0] S_INT_SC    = 5'd26;
   localparam logic [4:0] S_INT_UPD   = 5'd27;
   localparam logic [4:0] S_WR_NS     = 5'd28;
   localparam logic [4:0] S_OUT_RD    = 5'd29;
   localparam logic [4:0] S_OUT_CAP   = 5'd30;
   localparam logic [4:0] S_OUT_WAIT  = 5'd31;

   // Integration phases.
   localparam logic [1:0] PH_ACCEL = 2'd0;
   localparam logic [1:0] PH_DAMP  = 2'd1;
   localparam logic [1:0] PH_MOVE  = 2'd2;

   function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
      logic signed [31:0] r;
      if ((&v[ACC_W-1:31]) || (~|v[ACC_W-1:31])) begin
         r = v[31:0];
      end else if (v[ACC_W-1]) begin
         r = 32'sh8000_0000;
      end else begin
         r = 32'sh7FFF_FFFF;
      end
      return r;
   endfunction

   // Configuration registers.
   logic [6:0]  body_count_ff;
   logic [30:0] softening_ff;
   logic [16:0] time_step_ff;
   logic [16:0] damping_ff;

   // Sequencer and datapath registers.
   logic [4:0]             state_ff, state_in;
   logic [CW-1:0]          n_ff, n_in;
   logic [AW-1:0]          i_ff, i_in;
   logic [AW-1:0]          j_ff, j_in;
   logic                   comp_ff, comp_in;
   logic [1:0]             ph_ff, ph_in;
   logic [IW-1:0]          it_ff, it_in;
   logic signed [31:0]     pi_ff [2];
   logic signed [31:0]     pi_in [2];
   logic signed [31:0]     vi_ff [2];
   logic signed [31:0]     vi_in [2];
   logic [32:0]            mag_ff [2];
   logic [32:0]            mag_in [2];
   logic                   neg_ff [2];
   logic                   neg_in [2];
   logic signed [ACC_W-1:0] acc_ff [2];
   logic signed [ACC_W-1:0] acc_in [2];
   logic [MASS_W-1:0]      mass_ff, mass_in;
   logic [D2_W-1:0]        sq_ff, sq_in;
   logic [31:0]            f_ff, f_in;
   logic signed [TE_W-1:0] te_ff, te_in;
   logic [31:0]            y_ff, y_in;
   logic [32:0]            y2_ff, y2_in;
   logic [31:0]            t_ff, t_in;
   logic [31:0]            u_ff, u_in;
   logic [48:0]            c_ff, c_in;
   logic [31:0]            opm_ff, opm_in;
   logic                   opneg_ff, opneg_in;
   logic signed [31:0]     s_ff, s_in;

   // Response register.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic [5:0]             rsp_index_ff, rsp_index_in;
   logic [127:0]           rsp_data_ff, rsp_data_in;

   // Body stores and their registered read data.
   logic [63:0]        pos_mem  [MAX_BODIES];
   logic [63:0]        vel_mem  [MAX_BODIES];
   logic [MASS_W-1:0]  mass_mem [MAX_BODIES];
   logic [127:0]       ns_mem   [MAX_BODIES];
   logic [63:0]        pos_rd_ff;
   logic [63:0]        vel_rd_ff;
   logic [MASS_W-1:0]  mass_rd_ff;
   logic [127:0]       ns_rd_ff;

   // Shared units.
   logic [MUL_W-1:0]       op_a, op_b;
   logic [PROD_W-1:0]      prod_ff;
   logic                   norm_start, norm_done;
   logic [31:0]            norm_f;
   logic signed [TE_W-1:0] norm_te;

   // Miscellaneous combinational values.
   logic                   load_fire;
   logic [AW-1:0]          rd_addr;
   logic                   pos_we;
   logic [AW-1:0]          pos_wa;
   logic [127:0]           pos_wd;
   logic [CW-1:0]          step_n;
   logic                   j_last, i_last;
   logic signed [32:0]     rdiff [2];
   logic [D2_W-1:0]        d2_sum;
   logic [32:0]            fy;
   logic [32:0]            yt;
   logic [6:0]             u_sh_full;
   logic [64:0]            u_shift;
   logic [6:0]             csh;
   logic [32:0]            p_sc;
   logic signed [33:0]     s_term;
   logic signed [31:0]     int_src;

   nbds_mul u_mul (
      .clock   (clock),
      .op_a    (op_a),
      .op_b    (op_b),
      .prod_ff (prod_ff)
   );

   nbds_norm u_norm (
      .clock (clock),
      .reset (reset),
      .start (norm_start),
      .d2    (d2_sum),
      .done  (norm_done),
      .f     (norm_f),
      .two_e (norm_te)
   );

   // Handshakes and outputs.
   assign req_if.ready     = (state_ff == S_IDLE);
   assign csr_if.ready     = 1'b1;
   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.last      = rsp_last_ff;
   assign rsp_if.out_index = rsp_index_ff;
   assign rsp_if.new_pos_x = rsp_data_ff[127:96];
   assign rsp_if.new_pos_y = rsp_data_ff[95:64];
   assign rsp_if.new_vel_x = rsp_data_ff[63:32];
   assign rsp_if.new_vel_y = rsp_data_ff[31:0];

   assign load_fire = req_if.valid && (state_ff == S_IDLE) && (req_if.func == FUNC_LOAD)
                      && ({1'b0, req_if.index} < 7'(MAX_BODIES));

   assign step_n = (body_count_ff > 7'(MAX_BODIES)) ? CW'(MAX_BODIES) : CW'(body_count_ff);
   assign j_last = (j_ff == AW'(n_ff - CW'(1)));
   assign i_last = (i_ff == AW'(n_ff - CW'(1)));
   assign rd_addr = (state_ff == S_BODY_RD) ? i_ff : j_ff;

   // Store write port: loads, and the copy-back while results go out.
   always_comb begin
      pos_we = 1'b0;
      pos_wa = i_ff;
      pos_wd = ns_rd_ff;
      if (load_fire) begin
         pos_we = 1'b1;
         pos_wa = req_if.index[AW-1:0];
         pos_wd = {req_if.pos_x, req_if.pos_y, req_if.vel_x, req_if.vel_y};
      end else if (state_ff == S_OUT_CAP) begin
         pos_we = 1'b1;
      end
   end

   // Pair arithmetic that feeds the sequencer.
   assign rdiff[0] = $signed({pos_rd_ff[63], pos_rd_ff[63:32]})
                     - $signed({pi_ff[0][31], pi_ff[0]});
   assign rdiff[1] = $signed({pos_rd_ff[31], pos_rd_ff[31:0]})
                     - $signed({pi_ff[1][31], pi_ff[1]});
   assign d2_sum    = sq_ff + D2_W'(prod_ff[64:16]);
   assign norm_start = (state_ff == S_D2) && (d2_sum != '0);
   assign fy        = prod_ff[64:32];
   assign yt        = prod_ff[63:31];
   assign u_sh_full = 7'd16 + $unsigned(te_ff >>> 1);
   assign u_shift   = prod_ff[64:0] >> u_sh_full[5:0];
   assign csh       = $unsigned(te_ff) + 7'd30;
   assign p_sc      = prod_ff[48:16];
   assign s_term    = opneg_ff ? -$signed({1'b0, p_sc}) : $signed({1'b0, p_sc});
   assign int_src   = (ph_ff == PH_ACCEL) ? sat32(acc_ff[comp_ff]) : vi_ff[comp_ff];

   // Multiplier operand selection.
   always_comb begin
      op_a = '0;
      op_b = '0;
      case (state_ff)
         S_SQ_X: begin
            op_a = MUL_W'(mag_ff[0]);
            op_b = MUL_W'(mag_ff[0]);
         end
         S_SQ_Y: begin
            op_a = MUL_W'(mag_ff[1]);
            op_b = MUL_W'(mag_ff[1]);
         end
         S_SEED: begin
            if (f_ff[31]) begin
               op_a = MUL_W'(f_ff[30:0]);
               op_b = MUL_W'(SLOPE_HIGH);
            end else begin
               op_a = MUL_W'(f_ff[29:0]);
               op_b = MUL_W'(SLOPE_LOW);
            end
         end
         S_NT_A, S_FIN_A: begin
            op_a = MUL_W'(y_ff);
            op_b = MUL_W'(y_ff);
         end
         S_NT_B: begin
            op_a = MUL_W'(f_ff);
            op_b = MUL_W'(prod_ff[62:30]);
         end
         S_NT_D: begin
            op_a = MUL_W'(y_ff);
            op_b = MUL_W'(t_ff);
         end
         S_FIN_M: begin
            op_a = MUL_W'(mag_ff[comp_ff]);
            op_b = MUL_W'(y_ff);
         end
         S_FIN_UY: begin
            op_a = MUL_W'(u_ff);
            op_b = MUL_W'(y2_ff);
         end
         S_FIN_T: begin
            op_a = MUL_W'(mass_ff);
            op_b = prod_ff[63:30];
         end
         S_INT_MUL: begin
            op_a = MUL_W'(opm_ff);
            op_b = (ph_ff == PH_DAMP) ? MUL_W'(damping_ff) : MUL_W'(time_step_ff);
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      comp_in      = comp_ff;
      ph_in        = ph_ff;
      it_in        = it_ff;
      pi_in        = pi_ff;
      vi_in        = vi_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      acc_in       = acc_ff;
      mass_in      = mass_ff;
      sq_in        = sq_ff;
      f_in         = f_ff;
      te_in        = te_ff;
      y_in         = y_ff;
      y2_in        = y2_ff;
      t_in         = t_ff;
      u_in         = u_ff;
      c_in         = c_ff;
      opm_in       = opm_ff;
      opneg_in     = opneg_ff;
      s_in         = s_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_index_in = rsp_index_ff;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_if.valid && (req_if.func == FUNC_STEP) && (step_n != '0)) begin
               n_in     = step_n;
               i_in     = '0;
               state_in = S_BODY_RD;
            end
         end
         S_BODY_RD: begin
            state_in = S_BODY_CAP;
         end
         S_BODY_CAP: begin
            pi_in[0] = pos_rd_ff[63:32];
            pi_in[1] = pos_rd_ff[31:0];
            vi_in[0] = vel_rd_ff[63:32];
            vi_in[1] = vel_rd_ff[31:0];
            acc_in[0] = '0;
            acc_in[1] = '0;
            j_in     = '0;
            state_in = S_PAIR_RD;
         end
         S_PAIR_RD: begin
            state_in = S_PAIR_DIFF;
         end
         S_PAIR_DIFF: begin
            for (int k = 0; k < 2; k++) begin
               neg_in[k] = rdiff[k][32];
               mag_in[k] = rdiff[k][32] ? 33'(-rdiff[k]) : 33'(rdiff[k]);
            end
            mass_in  = mass_rd_ff;
            state_in = S_SQ_X;
         end
         S_SQ_X: begin
            state_in = S_SQ_Y;
         end
         S_SQ_Y: begin
            sq_in    = D2_W'(prod_ff[64:16]) + D2_W'(softening_ff);
            state_in = S_D2;
         end
         S_D2: begin
            // A pair at zero distance adds nothing.
            if (d2_sum == '0) begin
               if (j_last) begin
                  comp_in  = 1'b0;
                  ph_in    = PH_ACCEL;
                  state_in = S_INT_MAG;
               end else begin
                  j_in     = j_ff + AW'(1);
                  state_in = S_PAIR_RD;
               end
            end else begin
               state_in = S_NORM;
            end
         end
         S_NORM: begin
            if (norm_done) begin
               f_in     = norm_f;
               te_in    = norm_te;
               state_in = S_SEED;
            end
         end
         S_SEED: begin
            state_in = S_SEED_Y;
         end
         S_SEED_Y: begin
            y_in     = (f_ff[31] ? Q30_SQRT2 : Q30_TWO) - prod_ff[63:32];
            it_in    = '0;
            state_in = S_NT_A;
         end
         S_NT_A: begin
            state_in = S_NT_B;
         end
         S_NT_B: begin
            state_in = S_NT_C;
         end
         S_NT_C: begin
            t_in     = (fy >= {1'b0, Q30_THREE}) ? '0 : 32'({1'b0, Q30_THREE} - fy);
            state_in = S_NT_D;
         end
         S_NT_D: begin
            state_in = S_NT_E;
         end
         S_NT_E: begin
            y_in = (yt > {1'b0, Q30_TWO}) ? Q30_TWO : yt[31:0];
            if (it_ff == IW'(RSQRT_ITERATIONS - 1)) begin
               state_in = S_FIN_A;
            end else begin
               it_in    = it_ff + IW'(1);
               state_in = S_NT_A;
            end
         end
         S_FIN_A: begin
            state_in = S_FIN_B;
         end
         S_FIN_B: begin
            y2_in    = prod_ff[62:30];
            comp_in  = 1'b0;
            state_in = S_FIN_M;
         end
         S_FIN_M: begin
            state_in = S_FIN_U;
         end
         S_FIN_U: begin
            u_in     = (u_shift > 65'(Q30_TWO)) ? Q30_TWO : u_shift[31:0];
            state_in = S_FIN_UY;
         end
         S_FIN_UY: begin
            state_in = S_FIN_T;
         end
         S_FIN_T: begin
            state_in = S_FIN_C;
         end
         S_FIN_C: begin
            c_in     = (csh >= 7'd64) ? '0 : 49'(prod_ff[64:0] >> csh[5:0]);
            state_in = S_FIN_ACC;
         end
         S_FIN_ACC: begin
            if (neg_ff[comp_ff]) begin
               acc_in[comp_ff] = acc_ff[comp_ff] - $signed(ACC_W'(c_ff));
            end else begin
               acc_in[comp_ff] = acc_ff[comp_ff] + $signed(ACC_W'(c_ff));
            end
            if (!comp_ff) begin
               comp_in  = 1'b1;
               state_in = S_FIN_M;
            end else begin
               comp_in = 1'b0;
               if (j_last) begin
                  ph_in    = PH_ACCEL;
                  state_in = S_INT_MAG;
               end else begin
                  j_in     = j_ff + AW'(1);
                  state_in = S_PAIR_RD;
               end
            end
         end
         S_INT_MAG: begin
            opneg_in = int_src[31];
            opm_in   = int_src[31] ? (~$unsigned(int_src) + 32'd1) : $unsigned(int_src);
            state_in = S_INT_MUL;
         end
         S_INT_MUL: begin
            state_in = S_INT_SC;
         end
         S_INT_SC: begin
            s_in     = sat32(ACC_W'(s_term));
            state_in = S_INT_UPD;
         end
         S_INT_UPD: begin
            case (ph_ff)
               PH_ACCEL: begin
                  vi_in[comp_ff] = sat32(ACC_W'(vi_ff[comp_ff]) + ACC_W'(s_ff));
                  ph_in    = PH_DAMP;
                  state_in = S_INT_MAG;
               end
               PH_DAMP: begin
                  vi_in[comp_ff] = s_ff;
                  ph_in    = PH_MOVE;
                  state_in = S_INT_MAG;
               end
               default: begin
                  pi_in[comp_ff] = sat32(ACC_W'(pi_ff[comp_ff]) + ACC_W'(s_ff));
                  ph_in = PH_ACCEL;
                  if (!comp_ff) begin
                     comp_in  = 1'b1;
                     state_in = S_INT_MAG;
                  end else begin
                     comp_in  = 1'b0;
                     state_in = S_WR_NS;
                  end
               end
            endcase
         end
         S_WR_NS: begin
            if (i_last) begin
               i_in     = '0;
               state_in = S_OUT_RD;
            end else begin
               i_in     = i_ff + AW'(1);
               state_in = S_BODY_RD;
            end
         end
         S_OUT_RD: begin
            state_in = S_OUT_CAP;
         end
         S_OUT_CAP: begin
            rsp_valid_in = 1'b1;
            rsp_last_in  = i_last;
            rsp_index_in = 6'(i_ff);
            rsp_data_in  = ns_rd_ff;
            state_in     = S_OUT_WAIT;
         end
         S_OUT_WAIT: begin
            if (rsp_if.ready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  i_in     = i_ff + AW'(1);
                  state_in = S_OUT_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         body_count_ff <= BODY_COUNT_RESET;
         softening_ff  <= SOFTENING_RESET;
         time_step_ff  <= TIME_STEP_RESET;
         damping_ff    <= DAMPING_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_if.valid) begin
            case (csr_if.index)
               CSR_BODY_COUNT: body_count_ff <= csr_if.data[6:0];
               CSR_SOFTENING:  softening_ff  <= csr_if.data[30:0];
               CSR_TIME_STEP:  time_step_ff  <= csr_if.data[16:0];
               CSR_DAMPING:    damping_ff    <= csr_if.data[16:0];
               default:        body_count_ff <= body_count_ff;
            endcase
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      i_ff         <= i_in;
      j_ff         <= j_in;
      comp_ff      <= comp_in;
      ph_ff        <= ph_in;
      it_ff        <= it_in;
      pi_ff        <= pi_in;
      vi_ff        <= vi_in;
      mag_ff       <= mag_in;
      neg_ff       <= neg_in;
      acc_ff       <= acc_in;
      mass_ff      <= mass_in;
      sq_ff        <= sq_in;
      f_ff         <= f_in;
      te_ff        <= te_in;
      y_ff         <= y_in;
      y2_ff        <= y2_in;
      t_ff         <= t_in;
      u_ff         <= u_in;
      c_ff         <= c_in;
      opm_ff       <= opm_in;
      opneg_ff     <= opneg_in;
      s_ff         <= s_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_index_ff <= rsp_index_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // Body stores: one write and one registered read each per cycle.
   always_ff @(posedge clock) begin
      if (pos_we) begin
         pos_mem[pos_wa] <= pos_wd[127:64];
         vel_mem[pos_wa] <= pos_wd[63:0];
      end
      if (load_fire) begin
         mass_mem[req_if.index[AW-1:0]] <= req_if.mass;
      end
      if (state_ff == S_WR_NS) begin
         ns_mem[i_ff] <= {pi_ff[0], pi_ff[1], vi_ff[0], vi_ff[1]};
      end
      pos_rd_ff  <= pos_mem[rd_addr];
      vel_rd_ff  <= vel_mem[rd_addr];
      mass_rd_ff <= mass_mem[rd_addr];
      ns_rd_ff   <= ns_mem[i_ff];
   end

endmodule
